// ----- rtl/core/skts_pkg.sv -----
// Shared types and constants for the sorted key table search engine.
// No dependencies; imported by sorted_key_table_search and skts_engine.
package skts_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int POS_W    = 10;
  localparam int CMP_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 2;

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_SORTED   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_METHOD = 1'd1;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // search methods; the reserved code runs as linear
  localparam logic [1:0] METHOD_BINARY    = 2'd0;
  localparam logic [1:0] METHOD_LINEAR    = 2'd1;
  localparam logic [1:0] METHOD_TRANSPOSE = 2'd2;

  // result status
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_FOUND     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic       keep_sorted;
    logic [1:0] search_method;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic [CMP_W-1:0] comparisons;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ----- rtl/core/sorted_key_table_search.sv -----
// Sorted insert reads the table from the top, shifting each larger key up one slot,
// then writes the new key; a linear hit with transpose also swaps the key with its left
// neighbour; binary search halves the range at each probe until a hit or an empty range.
// One item at a time: the next item is accepted once the result is registered.
// Reset (rst, synchronous): table empty, keep_sorted 1, search_method binary.
// Top level: configuration registers, result register; uses skts_pkg, skts_engine, skts_ram.
module sorted_key_table_search
  import skts_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic                    opcode,
  input  logic signed [KEY_W-1:0] key,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic [1:0]              status,
  output logic [POS_W-1:0]        position,
  output logic [CMP_W-1:0]        comparisons,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  cfg_t             cfg;
  logic             idle;
  logic             res_valid;
  logic             res_take;
  res_t             res;
  mem_req_t         mem;
  logic [KEY_W-1:0] rd_data;

  assign cfg_ready = 1'b1;
  assign req_ready = idle;
  // load the result register when it is empty or its beat leaves this cycle
  assign res_take  = res_valid && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keep_sorted   <= 1'b1;
      cfg.search_method <= METHOD_BINARY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEEP_SORTED:   cfg.keep_sorted   <= cfg_data[0];
        REG_SEARCH_METHOD: cfg.search_method <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (res_take) begin
      status      <= res.status;
      position    <= res.position;
      comparisons <= res.comparisons;
    end
  end

  skts_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (req_valid && req_ready),
    .opcode    (opcode),
    .key       (key),
    .cfg       (cfg),
    .idle      (idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem       (mem),
    .rd_data   (rd_data)
  );

  skts_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_store (
    .clk     (clk),
    .wr_en   (mem.wr_en),
    .wr_addr (mem.wr_addr),
    .wr_data (mem.wr_data),
    .rd_en   (mem.rd_en),
    .rd_addr (mem.rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ----- rtl/core/skts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module skts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/skts_engine.sv -----
// Sequencer for insert and search over the key store, with one shared signed
// comparator on the RAM read data. Depends on skts_pkg.
module skts_engine
  import skts_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    opcode,
  input  logic signed [KEY_W-1:0] key,
  input  cfg_t                    cfg,
  output logic                    idle,
  output logic                    res_valid,
  input  logic                    res_take,
  output res_t                    res,
  output mem_req_t                mem,
  input  logic [KEY_W-1:0]        rd_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS     = 3'd1;
  localparam logic [2:0] S_INS_PUT = 3'd2;
  localparam logic [2:0] S_LIN     = 3'd3;
  localparam logic [2:0] S_SWAP    = 3'd4;
  localparam logic [2:0] S_BIN_ISS = 3'd5;
  localparam logic [2:0] S_BIN_CMP = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0]              state, state_next;
  logic signed [KEY_W-1:0] key_r, key_r_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        idx, idx_next;
  logic [CNT_W-1:0]        lo, lo_next;
  logic [CNT_W-1:0]        hi1, hi1_next;
  logic [ADDR_W-1:0]       mid, mid_next;
  logic [CNT_W-1:0]        probes, probes_next;
  logic [KEY_W-1:0]        prev, prev_next;
  logic                    transpose, transpose_next;
  res_t                    res_next;

  logic              rd_eq, rd_gt;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  idx_dec, idx_dec2, idx_inc;

  function automatic logic [ADDR_W-1:0] count_dec(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] d;
    d = c - CNT_W'(1);
    return d[ADDR_W-1:0];
  endfunction

  // shared comparator
  assign rd_eq = (rd_data == key_r);
  assign rd_gt = ($signed(rd_data) > key_r);

  assign mid_sum  = {1'b0, lo} + {1'b0, hi1} - {{CNT_W{1'b0}}, 1'b1};
  assign idx_dec  = idx - CNT_W'(1);
  assign idx_dec2 = idx - CNT_W'(2);
  assign idx_inc  = idx + CNT_W'(1);

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  always_comb begin
    state_next     = state;
    key_r_next     = key_r;
    count_next     = count;
    idx_next       = idx;
    lo_next        = lo;
    hi1_next       = hi1;
    mid_next       = mid;
    probes_next    = probes;
    prev_next      = prev;
    transpose_next = transpose;
    res_next       = res;
    mem            = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          key_r_next = key;
          if (opcode == OP_INSERT) begin
            if (count == CAP_COUNT) begin
              res_next   = '{ST_FULL, '0, '0};
              state_next = S_FIN;
            end else if (!cfg.keep_sorted || count == '0) begin
              mem.wr_en   = 1'b1;
              mem.wr_addr = count[ADDR_W-1:0];
              mem.wr_data = key;
              count_next  = count + CNT_W'(1);
              res_next    = '{ST_INSERTED, '0, '0};
              state_next  = S_FIN;
            end else begin
              idx_next    = count;
              mem.rd_en   = 1'b1;
              mem.rd_addr = count_dec(count);
              state_next  = S_INS;
            end
          end else if (cfg.search_method == METHOD_BINARY) begin
            lo_next     = '0;
            hi1_next    = count;
            probes_next = '0;
            state_next  = S_BIN_ISS;
          end else if (count == '0) begin
            res_next   = '{ST_NOT_FOUND, '0, '0};
            state_next = S_FIN;
          end else begin
            idx_next       = '0;
            transpose_next = (cfg.search_method == METHOD_TRANSPOSE);
            mem.rd_en      = 1'b1;
            mem.rd_addr    = '0;
            state_next     = S_LIN;
          end
        end
      end

      S_INS: begin
        if (rd_gt) begin
          // shift the larger key up one slot
          mem.wr_en   = 1'b1;
          mem.wr_addr = idx[ADDR_W-1:0];
          mem.wr_data = rd_data;
          idx_next    = idx_dec;
          if (idx == CNT_W'(1)) begin
            state_next = S_INS_PUT;
          end else begin
            mem.rd_en   = 1'b1;
            mem.rd_addr = idx_dec2[ADDR_W-1:0];
          end
        end else begin
          mem.wr_en   = 1'b1;
          mem.wr_addr = idx[ADDR_W-1:0];
          mem.wr_data = key_r;
          count_next  = count + CNT_W'(1);
          res_next    = '{ST_INSERTED, '0, '0};
          state_next  = S_FIN;
        end
      end

      S_INS_PUT: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = idx[ADDR_W-1:0];
        mem.wr_data = key_r;
        count_next  = count + CNT_W'(1);
        res_next    = '{ST_INSERTED, '0, '0};
        state_next  = S_FIN;
      end

      S_LIN: begin
        if (rd_eq) begin
          res_next = '{ST_FOUND, POS_W'(idx), CMP_W'(idx_inc)};
          if (transpose && idx != '0) begin
            // left neighbour takes the hit; the old neighbour goes back in S_SWAP
            mem.wr_en   = 1'b1;
            mem.wr_addr = idx_dec[ADDR_W-1:0];
            mem.wr_data = rd_data;
            state_next  = S_SWAP;
          end else begin
            state_next = S_FIN;
          end
        end else if (idx_inc == count) begin
          res_next   = '{ST_NOT_FOUND, '0, CMP_W'(count)};
          state_next = S_FIN;
        end else begin
          // hold this key as the left neighbour of the next probe
          prev_next   = rd_data;
          mem.rd_en   = 1'b1;
          mem.rd_addr = idx_inc[ADDR_W-1:0];
          idx_next    = idx_inc;
        end
      end

      S_SWAP: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = idx[ADDR_W-1:0];
        mem.wr_data = prev;
        state_next  = S_FIN;
      end

      S_BIN_ISS: begin
        if (lo < hi1) begin
          mid_next    = mid_sum[ADDR_W:1];
          mem.rd_en   = 1'b1;
          mem.rd_addr = mid_sum[ADDR_W:1];
          probes_next = probes + CNT_W'(1);
          state_next  = S_BIN_CMP;
        end else begin
          res_next   = '{ST_NOT_FOUND, '0, CMP_W'(probes)};
          state_next = S_FIN;
        end
      end

      S_BIN_CMP: begin
        if (rd_eq) begin
          res_next   = '{ST_FOUND, POS_W'(mid), CMP_W'(probes)};
          state_next = S_FIN;
        end else begin
          if (rd_gt) begin
            hi1_next = CNT_W'(mid);
          end else begin
            lo_next = CNT_W'(mid) + CNT_W'(1);
          end
          state_next = S_BIN_ISS;
        end
      end

      S_FIN: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    key_r     <= key_r_next;
    idx       <= idx_next;
    lo        <= lo_next;
    hi1       <= hi1_next;
    mid       <= mid_next;
    probes    <= probes_next;
    prev      <= prev_next;
    transpose <= transpose_next;
    res       <= res_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_COUNT)
    else $error("entry count above capacity");

  a_insert_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_INSERTED || res.status == ST_FULL)
      |-> res.position == '0 && res.comparisons == '0)
    else $error("insert result carries position or comparisons");

  a_found_probe: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_FOUND |-> res.comparisons != '0)
    else $error("hit reported with no comparison");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    idle && start |=> !idle)
    else $error("engine idle after accepting an item");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> count == $past(count) + CNT_W'(1))
    else $error("entry count moved by other than one");

endmodule
